// File: sv/tpr_pkg.sv
// Tile pixel rasterizer package: field widths, request codes, a helper function.
// No dependencies.
package tpr_pkg;
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;
    localparam int PALETTE_DEPTH_DEF = 512;

    localparam logic [2:0] REQ_TILE   = 3'd0;
    localparam logic [2:0] REQ_WORD   = 3'd1;
    localparam logic [2:0] REQ_PAL    = 3'd2;
    localparam logic [2:0] REQ_SCROLL = 3'd3;
    localparam logic [2:0] REQ_SCAN   = 3'd4;

    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [6:0] ALPHA_MAX = 7'd64;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [8:0]  x_origin;
        logic [8:0]  y_origin;
        logic [20:0] tile_attr;
        logic [21:0] bitmap_base;
        logic [15:0] tile_number;
        logic [15:0] data_word;
        logic [16:0] location;
    } t_req;

    typedef struct packed {
        logic        result_kind;
        logic [21:0] fetch_address;
        logic [11:0] word_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_rsp;

    function automatic logic [7:0] grow5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction
endpackage

// File: sv/tpr_if.sv
// Valid/ready channel carrying one payload type.
// Depends on tpr_pkg.
interface tpr_req_if import tpr_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tpr_rsp_if import tpr_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/tpr_blend.sv
// Shared 8-bit blend unit: one channel per use, registered result.
// Depends on tpr_pkg.
module tpr_blend import tpr_pkg::*; (
    input  logic       i_clk,
    input  logic [6:0] i_alpha,
    input  logic [7:0] i_old,
    input  logic [7:0] i_new,
    output logic [7:0] o_mix
);
    logic [13:0] n_sum;
    logic [7:0]  r_mix;
    always_comb begin
        n_sum = 14'(ALPHA_MAX - i_alpha) * 14'(i_old) + 14'(i_alpha) * 14'(i_new);
    end
    always_ff @(posedge i_clk) begin
        r_mix <= n_sum[13:6];
    end
    assign o_mix = r_mix;
endmodule

// File: sv/tile_pixel_rasterizer.sv
// Tile pixel rasterizer top level: sequencer, frame/palette/scroll memories.
// Depends on tpr_pkg, tpr_if, tpr_blend.
// Usage:
//  i_req (valid/ready) carries requests; o_rsp carries results; i_cfg_we with
//  i_cfg_wdata writes the blend alpha r_alpha (values above 64 stored as 64).
//  A tile start answers with fetch address and word count once S_STEP has
//  computed the address; then graphics words are sent. Each word yields up
//  to 8 pixels; each pixel is one pass of the pixel sequencer through scroll
//  read, palette read, address, frame read and frame write, plus three uses
//  of the shared blend unit for blended tiles. A word holds i_req not ready
//  until its last frame write. Palette and scroll writes stay in S_IDLE; scan
//  out in the frame reads the pixel in S_SCAN, answers and clears it in S_SCAN2.
//  After reset a clearing pass zeroes the frame store, one pixel a cycle,
//  with i_req not ready.
//  A result waits in the output register; the block keeps taking non-result
//  items while it waits and stalls only a tile start or scan out.
module tile_pixel_rasterizer import tpr_pkg::*; #(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpr_req_if.sink    i_req,
    tpr_rsp_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata
);
    localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int FW = $clog2(FRAME_SIZE);
    localparam int PW = $clog2(PALETTE_DEPTH);
    localparam int SW = $clog2(SCREEN_HEIGHT);

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_WORD = 4'd2,
        S_PIX = 4'd3, S_PAL = 4'd4, S_FRD = 4'd5, S_BR = 4'd6, S_BG = 4'd7,
        S_BB = 4'd8, S_WR = 4'd9, S_SCAN = 4'd10, S_SCAN2 = 4'd11,
        S_STEP = 4'd12, S_SCR = 4'd13;

    logic [23:0] frame_mem [FRAME_SIZE];
    logic [15:0] pal_mem [PALETTE_DEPTH];
    logic [8:0]  scroll_mem [SCREEN_HEIGHT];

    logic [3:0]  r_state;
    logic [6:0]  r_alpha;
    logic [23:0] r_buf;
    logic [4:0]  r_held, n_held;
    logic [5:0]  r_col, n_col, r_row, n_row;
    logic [8:0]  r_tx, r_ty;
    logic [20:0] r_attr;
    logic        r_active, n_active;
    logic [FW-1:0] r_clr;
    logic        r_ovalid;
    t_rsp        r_rsp;
    logic [8:0]  r_xx, r_yy, n_xx, n_yy;
    logic [9:0]  r_pal;
    logic [15:0] r_rgb;
    logic [23:0] r_old;
    logic [FW-1:0] r_at;
    logic [8:0]  r_scr;
    logic [7:0]  r_mr, r_mg;
    logic        r_first;
    logic [15:0] r_bsw;
    logic [21:0] r_base;
    logic [15:0] r_tnum;

    logic [3:0]  nc;
    logic [6:0]  w, h;
    logic [7:0]  b_old, b_new, b_mix;
    logic [16:0] loc_q;
    logic        req_has_rsp;

    assign nc = ({2'b0, r_attr[1:0]} + 4'd1) << 1;
    assign w  = 7'(8) << r_attr[5:4];
    assign h  = 7'(8) << r_attr[7:6];
    assign loc_q = i_req.data.location;
    assign req_has_rsp = (i_req.data.req_type == REQ_TILE) || (i_req.data.req_type == REQ_SCAN);
    assign i_req.ready = (r_state == S_IDLE) && (!r_ovalid || !req_has_rsp);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    tpr_blend u_blend (
        .i_clk(i_clk), .i_alpha(r_alpha), .i_old(b_old), .i_new(b_new), .o_mix(b_mix)
    );

    always_comb begin
        case (r_state)
            S_BR: begin b_old = r_old[23:16]; b_new = grow5(r_rgb[14:10]); end
            S_BG: begin b_old = r_old[15:8];  b_new = grow5(r_rgb[9:5]);   end
            default: begin b_old = r_old[7:0]; b_new = grow5(r_rgb[4:0]); end
        endcase
    end

    // pixel position for current col/row
    always_comb begin
        n_xx = r_tx + 9'(r_col ^ (r_attr[2] ? 6'(w - 7'd1) : 6'd0));
        n_yy = r_ty + 9'(r_row ^ (r_attr[3] ? 6'(h - 7'd1) : 6'd0));
    end

    // unpack step and col/row advance
    logic [23:0] shifted;
    always_comb begin
        n_held = r_held; n_col = r_col; n_row = r_row;
        n_active = r_active;
        shifted = '0;
        if (r_first) begin
            shifted = (r_buf << nc) | (24'(r_bsw) << (nc - 4'(r_held)));
            n_held = r_held + 5'd16 - 5'(nc);
        end else begin
            shifted = r_buf << nc;
            n_held = r_held - 5'(nc);
        end
        if ({1'b0, r_col} + 7'd1 >= w) begin
            n_col = '0;
            if (7'(r_row) + 7'd1 >= h) begin
                n_row = '0; n_active = 1'b0;
            end else begin
                n_row = r_row + 6'd1;
            end
        end else begin
            n_col = r_col + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_alpha <= '0; r_buf <= '0; r_held <= '0;
            r_col <= '0; r_row <= '0; r_tx <= '0; r_ty <= '0; r_attr <= '0;
            r_active <= 1'b0; r_clr <= '0; r_ovalid <= 1'b0; r_first <= 1'b0;
        end else begin
            if (i_cfg_we) r_alpha <= (i_cfg_wdata > ALPHA_MAX) ? ALPHA_MAX : i_cfg_wdata;
            if (r_ovalid && o_rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + FW'(1);
                    if (r_clr == FW'(FRAME_SIZE - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        case (i_req.data.req_type)
                            REQ_TILE: begin
                                r_tx <= i_req.data.x_origin; r_ty <= i_req.data.y_origin;
                                r_attr <= i_req.data.tile_attr;
                                r_base <= i_req.data.bitmap_base;
                                r_tnum <= i_req.data.tile_number;
                                r_buf <= '0; r_held <= '0; r_col <= '0; r_row <= '0;
                                r_active <= 1'b1;
                                r_rsp <= '{result_kind: KIND_FETCH,
                                    word_count: 12'(({1'b0, i_req.data.tile_attr[1:0]}
                                    + 3'd1) * 2 * (8 << i_req.data.tile_attr[5:4])
                                    * (8 << i_req.data.tile_attr[7:6]) / 16),
                                    default: '0};
                                r_state <= S_STEP;
                            end
                            REQ_WORD: begin
                                if (r_active) begin
                                    r_bsw <= {i_req.data.data_word[7:0],
                                              i_req.data.data_word[15:8]};
                                    r_first <= 1'b1;
                                    r_state <= S_WORD;
                                end
                            end
                            REQ_PAL: begin
                                if (32'(loc_q) < PALETTE_DEPTH)
                                    pal_mem[loc_q[PW-1:0]] <= i_req.data.data_word;
                            end
                            REQ_SCROLL: begin
                                if (32'(loc_q) < SCREEN_HEIGHT)
                                    scroll_mem[loc_q[SW-1:0]] <= i_req.data.data_word[8:0];
                            end
                            REQ_SCAN: begin
                                r_rsp <= '{result_kind: KIND_PIXEL, default: '0};
                                r_at <= loc_q[FW-1:0];
                                if (32'(loc_q) < FRAME_SIZE) r_state <= S_SCAN;
                                else r_ovalid <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_STEP: begin
                    // fetch address: one 12x16 multiply
                    r_rsp.fetch_address <= r_base + 22'(r_rsp.word_count) * 22'(r_tnum);
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_WORD: begin
                    r_buf <= shifted;
                    r_held <= n_held;
                    r_first <= 1'b0;
                    r_state <= S_PIX;
                end
                S_PIX: begin
                    r_pal <= {2'b0, r_attr[11:8], 4'b0} + 10'(r_buf[23:16]);
                    r_buf <= {8'b0, r_buf[15:0]};
                    r_xx <= n_xx; r_yy <= n_yy;
                    if (32'(n_yy) < SCREEN_HEIGHT)
                        r_scr <= scroll_mem[n_yy[SW-1:0]];
                    r_state <= S_SCR;
                end
                S_SCR: begin
                    if (r_attr[20] && 32'(r_yy) < SCREEN_HEIGHT) r_xx <= r_xx - r_scr;
                    if (32'(r_pal) < PALETTE_DEPTH) r_rgb <= pal_mem[r_pal[PW-1:0]];
                    else r_rgb <= 16'h8000;
                    r_state <= S_PAL;
                end
                S_PAL: begin
                    r_at <= FW'(32'(r_xx) + SCREEN_WIDTH * 32'(r_yy));
                    r_state <= S_FRD;
                end
                S_FRD: begin
                    if (32'(r_xx) < SCREEN_WIDTH && 32'(r_yy) < SCREEN_HEIGHT
                        && !r_rgb[15]) begin
                        r_old <= frame_mem[r_at];
                        r_state <= r_attr[14] ? S_BR : S_WR;
                    end else begin
                        r_state <= S_WR;
                        r_rgb[15] <= 1'b1;
                    end
                end
                S_BR: r_state <= S_BG;
                S_BG: begin r_mr <= b_mix; r_state <= S_BB; end
                S_BB: begin r_mg <= b_mix; r_state <= S_WR; end
                S_WR: begin
                    r_col <= n_col; r_row <= n_row; r_active <= n_active;
                    if (n_active && r_held >= 5'(nc)) begin
                        r_buf <= shifted; r_held <= n_held; r_state <= S_PIX;
                    end else r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_old <= frame_mem[r_at];
                    r_state <= S_SCAN2;
                end
                S_SCAN2: begin
                    r_rsp.red <= r_old[23:16]; r_rsp.green <= r_old[15:8];
                    r_rsp.blue <= r_old[7:0];
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // frame write port (clearing pass, scan-out clear, pixel write)
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) frame_mem[r_clr] <= '0;
        else if (r_state == S_SCAN2) frame_mem[r_at] <= '0;
        else if (r_state == S_WR && !r_rgb[15]) begin
            if (r_attr[14]) frame_mem[r_at] <= {r_mr, r_mg, b_mix};
            else frame_mem[r_at] <= {grow5(r_rgb[14:10]),
                grow5(r_rgb[9:5]), grow5(r_rgb[4:0])};
        end
    end
endmodule

// File: sv/tpr_checker.sv
// Port-level checker for the tile pixel rasterizer, bound to the top level.
// Depends on tpr_pkg.
module tpr_checker import tpr_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [2:0] req_type,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input t_rsp       rsp_data
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && req_valid && req_ready |->
        req_type != REQ_TILE && req_type != REQ_SCAN)
        else $error("result request taken while result pending");
    a_pix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_data.result_kind == KIND_PIXEL |->
        rsp_data.fetch_address == '0 && rsp_data.word_count == '0)
        else $error("pixel result has fetch fields");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !rsp_valid && !req_ready)
        else $error("not quiet after reset");
endmodule

bind tile_pixel_rasterizer tpr_checker u_tpr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready), .req_type(i_req.data.req_type),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready), .rsp_data(o_rsp.data)
);
